FILE: hdl/rrts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrts_pkg
// shared constants for the round-robin thread scheduler
// ----------------------------------------------------------------------------
package rrts_pkg;

  localparam int MAX_THREADS_DEF = 16;
  localparam int COUNT_WIDTH_DEF = 32;

  localparam int FUNC_W  = 3;
  localparam int TID_W   = 4;
  localparam int SLEEP_W = 16;
  localparam int VALUE_W = 32;
  localparam int ST_W    = 3;

  localparam logic [FUNC_W-1:0] FN_TICK   = 3'd0;
  localparam logic [FUNC_W-1:0] FN_SPAWN  = 3'd1;
  localparam logic [FUNC_W-1:0] FN_TERM   = 3'd2;
  localparam logic [FUNC_W-1:0] FN_BLOCK  = 3'd3;
  localparam logic [FUNC_W-1:0] FN_RESUME = 3'd4;
  localparam logic [FUNC_W-1:0] FN_SLEEP  = 3'd5;
  localparam logic [FUNC_W-1:0] FN_QUERY  = 3'd6;

  localparam logic [ST_W-1:0] ST_FREE     = 3'd0;
  localparam logic [ST_W-1:0] ST_READY    = 3'd1;
  localparam logic [ST_W-1:0] ST_RUNNING  = 3'd2;
  localparam logic [ST_W-1:0] ST_BLOCKED  = 3'd3;
  localparam logic [ST_W-1:0] ST_SLEEPING = 3'd4;

  localparam logic [1:0] WHY_TICK  = 2'd0;
  localparam logic [1:0] WHY_EXIT  = 2'd1;
  localparam logic [1:0] WHY_BLOCK = 2'd2;
  localparam logic [1:0] WHY_SLEEP = 2'd3;

endpackage

FILE: hdl/round_robin_thread_scheduler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// round_robin_thread_scheduler
// round-robin scheduler of thread slots with block, resume and sleep
// ----------------------------------------------------------------------------
// usage:
//   a command (in_func, in_thread_id, in_sleep_quantums, in_entry_valid) is
//   taken at a rising edge with start high and busy low. busy then stays
//   high while a small sequencer walks the thread slots one per cycle.
//   the result appears on the out_ ports for one cycle with out_valid high;
//   the receiver cannot stall it, so it must take every transfer.
// command sequence (accept edge to next possible accept edge):
//   query, resume, error cases and a block of a sleeper pass the decode
//   state at most; spawn searches for a free slot from id 1; removal of a
//   ready thread from the queue first finds it, then shifts one entry per
//   cycle; a context switch (exit, block, sleep, tick) walks every slot
//   once for due sleepers, then pops the next thread; a tick requeues the
//   outgoing thread before the pop. the result strobe is the last cycle;
//   the next command can be taken at the edge that ends it.
// reset:
//   rst_n low at a rising edge returns slot 0 to running, all other slots free,
//   the ready queue empty and the quantum total one. terminating slot 0
//   repeats the same state by a restore in the decode step (the queue
//   store has no reset and is only read below its fill count).
// ----------------------------------------------------------------------------
module round_robin_thread_scheduler
  import rrts_pkg::*;
#(
  parameter int MAX_THREADS = MAX_THREADS_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [FUNC_W-1:0]  in_func,
  input  logic [TID_W-1:0]   in_thread_id,
  input  logic [SLEEP_W-1:0] in_sleep_quantums,
  input  logic               in_entry_valid,
  output logic               out_valid,
  output logic               out_error,
  output logic [VALUE_W-1:0] out_value,
  output logic [TID_W-1:0]   out_running_id,
  output logic [VALUE_W-1:0] out_total_quantums,
  output logic               out_process_exit
);

  localparam int IW = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;
  localparam int CW = $clog2(MAX_THREADS + 1);
  localparam int WS = ((COUNT_WIDTH > SLEEP_W) ? COUNT_WIDTH : SLEEP_W) + 1;
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

  // sequencer codes
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SPAWN = 3'd1;
  localparam logic [2:0] S_WAKE  = 3'd2;
  localparam logic [2:0] S_OUT   = 3'd3;
  localparam logic [2:0] S_POP   = 3'd4;
  localparam logic [2:0] S_RFND  = 3'd5;
  localparam logic [2:0] S_RSHF  = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  logic [2:0] state_r;

  // slot tables: small, each entry read at a chosen index
  logic [ST_W-1:0]        slot_r  [MAX_THREADS];
  logic [COUNT_WIDTH-1:0] wake_r  [MAX_THREADS];
  logic                   bpend_r [MAX_THREADS];
  logic [COUNT_WIDTH-1:0] runc_r  [MAX_THREADS];
  logic [IW-1:0]          fifo_r  [MAX_THREADS];

  logic [IW-1:0] head_r;
  logic [CW-1:0] cnt_r;
  logic [IW-1:0] cur_r;
  logic [COUNT_WIDTH-1:0] qtot_r;

  // command latch
  logic [FUNC_W-1:0]  func_r;
  logic [TID_W-1:0]   tid_r;
  logic [SLEEP_W-1:0] nq_r;
  logic [1:0]         why_r;
  logic [IW-1:0]      scan_r;   // slot walk / queue position
  logic               err_r;
  logic [VALUE_W-1:0] val_r;
  logic               pexit_r;
  logic               vld_r;

  logic [IW-1:0] t;
  logic          exists;
  assign t = IW'(tid_r);
  assign exists = ({{(32-TID_W){1'b0}}, tid_r} < 32'(MAX_THREADS)) && slot_r[t] != ST_FREE;

  function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
    sat_inc = (v == CNT_MAX) ? v : v + 1'b1;
  endfunction

  function automatic logic [IW-1:0] qpos(input logic [IW-1:0] h, input logic [CW-1:0] o);
    logic [CW:0] s;
    s = (CW+1)'(h) + (CW+1)'(o);
    if (s >= (CW+1)'(MAX_THREADS)) s = s - (CW+1)'(MAX_THREADS);
    qpos = s[IW-1:0];
  endfunction

  // sleep wake time, one add and compare
  logic [WS-1:0] wsum;
  logic          wsat;
  assign wsum = WS'(qtot_r) + WS'(nq_r) + WS'(1);
  assign wsat = (wsum > WS'(CNT_MAX));

  logic [IW-1:0] push_pos;
  assign push_pos = qpos(head_r, cnt_r);
  logic [IW-1:0] sh_a, sh_b;
  assign sh_a = qpos(head_r, CW'(scan_r));
  assign sh_b = qpos(head_r, CW'(scan_r) + 1'b1);

  logic last_scan;
  assign last_scan = (scan_r == IW'(MAX_THREADS - 1));

  assign busy = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    vld_r <= 1'b0;
    if (!rst_n) begin
      state_r <= S_IDLE;
      for (int i = 0; i < MAX_THREADS; i++) begin
        slot_r[i]  <= (i == 0) ? ST_RUNNING : ST_FREE;
        wake_r[i]  <= '0;
        bpend_r[i] <= 1'b0;
        runc_r[i]  <= (i == 0) ? COUNT_WIDTH'(1) : '0;
      end
      head_r <= '0;
      cnt_r  <= '0;
      cur_r  <= '0;
      qtot_r <= COUNT_WIDTH'(1);
      pexit_r <= 1'b0;
      err_r  <= 1'b0;
      val_r  <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            func_r <= in_func; tid_r <= in_thread_id;
            nq_r <= in_sleep_quantums;
            err_r <= 1'b0; val_r <= '0; pexit_r <= 1'b0;
            scan_r <= '0;
            state_r <= S_DONE;
            unique case (in_func)
              FN_TICK: begin
                why_r <= WHY_TICK; qtot_r <= sat_inc(qtot_r); state_r <= S_WAKE;
              end
              FN_SPAWN: begin
                err_r <= 1'b1;
                scan_r <= IW'(1);
                if (in_entry_valid && MAX_THREADS > 1) state_r <= S_SPAWN;
              end
              FN_TERM, FN_BLOCK, FN_RESUME, FN_QUERY: state_r <= S_OUT;
              FN_SLEEP: state_r <= S_OUT;
              default: err_r <= 1'b1;
            endcase
          end
        end
        S_SPAWN: begin
          if (slot_r[scan_r] == ST_FREE) begin
            slot_r[scan_r] <= ST_READY; runc_r[scan_r] <= '0;
            wake_r[scan_r] <= '0; bpend_r[scan_r] <= 1'b0;
            fifo_r[push_pos] <= scan_r; cnt_r <= cnt_r + 1'b1;
            val_r <= VALUE_W'(scan_r); err_r <= 1'b0;
            state_r <= S_DONE;
          end else if (last_scan) state_r <= S_DONE;
          else scan_r <= scan_r + 1'b1;
        end
        S_OUT: begin
          // decode of the targeted commands
          state_r <= S_DONE;
          scan_r <= '0;
          unique case (func_r)
            FN_TERM: begin
              if (!exists) err_r <= 1'b1;
              else if (t == '0) begin
                for (int i = 0; i < MAX_THREADS; i++) begin
                  slot_r[i]  <= (i == 0) ? ST_RUNNING : ST_FREE;
                  wake_r[i]  <= '0; bpend_r[i] <= 1'b0;
                  runc_r[i]  <= (i == 0) ? COUNT_WIDTH'(1) : '0;
                end
                head_r <= '0; cnt_r <= '0; cur_r <= '0;
                qtot_r <= COUNT_WIDTH'(1); pexit_r <= 1'b1;
              end else begin
                slot_r[t] <= ST_FREE; bpend_r[t] <= 1'b0;
                if (slot_r[t] == ST_READY) state_r <= S_RFND;
                else if (slot_r[t] == ST_RUNNING) begin
                  why_r <= WHY_EXIT; qtot_r <= sat_inc(qtot_r); state_r <= S_WAKE;
                end
              end
            end
            FN_BLOCK: begin
              if (!exists || t == '0) err_r <= 1'b1;
              else if (slot_r[t] == ST_SLEEPING) bpend_r[t] <= 1'b1;
              else if (slot_r[t] == ST_RUNNING) begin
                why_r <= WHY_BLOCK; qtot_r <= sat_inc(qtot_r); state_r <= S_WAKE;
              end else if (slot_r[t] == ST_READY) begin
                slot_r[t] <= ST_BLOCKED; state_r <= S_RFND;
              end
            end
            FN_RESUME: begin
              if (!exists) err_r <= 1'b1;
              else if (slot_r[t] == ST_SLEEPING) bpend_r[t] <= 1'b0;
              else if (slot_r[t] == ST_BLOCKED && cnt_r < CW'(MAX_THREADS)) begin
                slot_r[t] <= ST_READY; fifo_r[push_pos] <= t; cnt_r <= cnt_r + 1'b1;
              end else if (slot_r[t] == ST_BLOCKED) slot_r[t] <= ST_READY;
            end
            FN_SLEEP: begin
              if (nq_r == '0 || cur_r == '0) err_r <= 1'b1;
              else begin
                wake_r[cur_r] <= wsat ? CNT_MAX : wsum[COUNT_WIDTH-1:0];
                why_r <= WHY_SLEEP; qtot_r <= sat_inc(qtot_r); state_r <= S_WAKE;
              end
            end
            FN_QUERY: begin
              if (!exists) err_r <= 1'b1;
              else val_r <= VALUE_W'(runc_r[t]);
            end
            default: err_r <= 1'b1;
          endcase
        end
        S_RFND: begin
          // find target in the queue by walking positions
          if (CW'(scan_r) >= cnt_r) state_r <= S_DONE;
          else if (fifo_r[sh_a] == t) state_r <= S_RSHF;
          else scan_r <= scan_r + 1'b1;
        end
        S_RSHF: begin
          if (CW'(scan_r) + 1'b1 >= cnt_r) begin
            cnt_r <= cnt_r - 1'b1; state_r <= S_DONE;
          end else begin
            fifo_r[sh_a] <= fifo_r[sh_b]; scan_r <= scan_r + 1'b1;
          end
        end
        S_WAKE: begin
          // one slot per cycle through the wake compare
          if (slot_r[scan_r] == ST_SLEEPING && wake_r[scan_r] <= qtot_r) begin
            if (bpend_r[scan_r]) slot_r[scan_r] <= ST_BLOCKED;
            else begin
              slot_r[scan_r] <= ST_READY;
              if (cnt_r < CW'(MAX_THREADS)) begin
                fifo_r[push_pos] <= scan_r; cnt_r <= cnt_r + 1'b1;
              end
            end
          end
          if (last_scan) state_r <= S_POP;
          else scan_r <= scan_r + 1'b1;
          if (last_scan) begin
            unique case (why_r)
              WHY_BLOCK: slot_r[cur_r] <= ST_BLOCKED;
              WHY_SLEEP: begin slot_r[cur_r] <= ST_SLEEPING; bpend_r[cur_r] <= 1'b0; end
              WHY_TICK:  slot_r[cur_r] <= ST_READY;
              WHY_EXIT:  ;
            endcase
            why_r <= (why_r == WHY_TICK) ? WHY_TICK : WHY_EXIT;
          end
        end
        S_POP: begin
          // push outgoing on tick, then pop next cycle
          if (why_r == WHY_TICK && cnt_r < CW'(MAX_THREADS)) begin
            fifo_r[push_pos] <= cur_r; cnt_r <= cnt_r + 1'b1;
            why_r <= WHY_EXIT;
          end else begin
            if (cnt_r != '0) begin
              cur_r <= fifo_r[head_r];
              slot_r[fifo_r[head_r]] <= ST_RUNNING;
              runc_r[fifo_r[head_r]] <= sat_inc(runc_r[fifo_r[head_r]]);
              head_r <= (head_r == IW'(MAX_THREADS - 1)) ? '0 : head_r + 1'b1;
              cnt_r <= cnt_r - 1'b1;
            end
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          vld_r <= 1'b1;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid          = vld_r;
  assign out_error          = err_r;
  assign out_value          = err_r ? '0 : val_r;
  assign out_running_id     = TID_W'(cur_r);
  assign out_total_quantums = VALUE_W'(qtot_r);
  assign out_process_exit   = pexit_r;

  // a result strobe always ends a command and leaves the block free
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("result while busy");
  // the running slot is marked running when idle
  a_cur_run: assert property (@(posedge clk) disable iff (!rst_n)
    !busy |-> slot_r[cur_r] == ST_RUNNING) else $error("current slot not running");
  // queue fill never exceeds the slot count
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_THREADS)) else $error("queue overfill");
  // main exit leaves the reset total
  a_exit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_process_exit |-> out_total_quantums == VALUE_W'(1))
    else $error("exit total wrong");

endmodule
